>>> hw/rtl/wbr_pkg.sv
package wbr_pkg;

  // Fixed-point one in Q1.16 and field widths.
  localparam int unsigned OneQ16     = 65536;
  localparam int unsigned PixelW     = 32;
  localparam int unsigned SumW       = 32;
  localparam int unsigned RevealW    = 17;
  localparam int unsigned NumChan    = 3;
  // Remainder width of the divider: numerator below 255 * (A << 16).
  localparam int unsigned RemW       = 56;
  // Number of divider stages, one quotient bit each.
  localparam int unsigned DivStages  = 8;

  // One word inside the divider part of the pipeline.
  typedef struct packed {
    logic [PixelW-1:0]              px;
    logic                           zero;
    logic [7:0]                     alpha;
    logic [NumChan-1:0]             sat;
    logic [NumChan-1:0][RemW-1:0]   rem;
    logic [NumChan-1:0][7:0]        quo;
    logic [SumW-1:0]                den;
  } div_t;

endpackage

>>> hw/rtl/wbr_in_if.sv
interface wbr_in_if;
  logic                            valid;
  logic                            ready;
  logic [wbr_pkg::PixelW-1:0]      dest_pixel;
  logic [wbr_pkg::SumW-1:0]        sum_red;
  logic [wbr_pkg::SumW-1:0]        sum_green;
  logic [wbr_pkg::SumW-1:0]        sum_blue;
  logic [wbr_pkg::SumW-1:0]        sum_alpha;
  logic [wbr_pkg::RevealW-1:0]     reveal;

  modport source (output valid, dest_pixel, sum_red, sum_green, sum_blue, sum_alpha, reveal,
                  input ready);
  modport sink (input valid, dest_pixel, sum_red, sum_green, sum_blue, sum_alpha, reveal,
                output ready);
endinterface

>>> hw/rtl/wbr_out_if.sv
interface wbr_out_if;
  logic                        valid;
  logic                        ready;
  logic [wbr_pkg::PixelW-1:0]  out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink (input valid, out_pixel, output ready);
endinterface

>>> hw/rtl/weighted_blend_resolve.sv
// Path: stages 1-3, divider entry, divider stages, output register. Throughput: one word
// per cycle unless the output stalls; each stage holds a valid bit and stalls on its own,
// so bubbles are squeezed out; with the output stalled the input backs up after 13 words.
// Depth is set by the eight-stage restoring divider, one quotient bit per stage.
// Reset: rst_ni clears all valid bits asynchronously; the data registers are not reset.
module weighted_blend_resolve (
  input  logic      clk_i,
  input  logic      rst_ni,
  wbr_in_if.sink    in_i,
  wbr_out_if.source out_o
);

  localparam int unsigned NDiv = wbr_pkg::DivStages;

  // Stage 1 registers: unpacked operands.
  logic                                        v1_q;
  logic [wbr_pkg::PixelW-1:0]                  px1_q;
  logic                                        zero1_q;
  logic [wbr_pkg::NumChan-1:0][wbr_pkg::SumW-1:0] c1_q;
  logic [wbr_pkg::NumChan-1:0][7:0]            d1_q;
  logic [wbr_pkg::SumW-1:0]                    adiv1_q;
  logic [wbr_pkg::SumW-1:0]                    araw1_q;
  logic [wbr_pkg::RevealW-1:0]                 rv1_q;
  logic [wbr_pkg::RevealW-1:0]                 inv1_q;

  // Stage 2 registers: first products.
  logic                                        v2_q;
  logic [wbr_pkg::PixelW-1:0]                  px2_q;
  logic                                        zero2_q;
  logic [wbr_pkg::NumChan-1:0][48:0]           p2_q;
  logic [wbr_pkg::NumChan-1:0][24:0]           dr2_q;
  logic [wbr_pkg::SumW-1:0]                    adiv2_q;
  logic [48:0]                                 pa2_q;

  // Stage 3 registers: full numerators.
  logic                                        v3_q;
  logic [wbr_pkg::PixelW-1:0]                  px3_q;
  logic                                        zero3_q;
  logic [wbr_pkg::NumChan-1:0][57:0]           num3_q;
  logic [wbr_pkg::SumW-1:0]                    adiv3_q;
  logic [39:0]                                 a2553_q;
  logic [56:0]                                 anum3_q;

  // Divider stages; index 0 holds the saturation check, 1..NDiv one bit each.
  logic [NDiv:0]                               dv_q;
  wbr_pkg::div_t                               div_q [NDiv+1];
  wbr_pkg::div_t                               div_d [NDiv+1];

  // Output register.
  logic                                        ov_q;
  logic [wbr_pkg::PixelW-1:0]                  opx_q;
  logic [wbr_pkg::PixelW-1:0]                  opx_d;

  // Per-stage load enables, chained back from the output.
  logic                                        en_o;
  logic [NDiv:0]                               en_div;
  logic                                        en1, en2, en3;

  logic                                        sums_zero;
  logic                                        alpha_zero;
  logic [wbr_pkg::RevealW-1:0]                 rv_sat;

  assign en_o = !ov_q || out_o.ready;
  always_comb begin
    en_div[NDiv] = !dv_q[NDiv] || en_o;
    for (int j = NDiv - 1; j >= 0; j--) begin
      en_div[j] = !dv_q[j] || en_div[j+1];
    end
  end
  assign en3 = !v3_q || en_div[0];
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      dv_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_div[0]) dv_q[0] <= v3_q;
      for (int j = 1; j <= NDiv; j++) begin
        if (en_div[j]) dv_q[j] <= dv_q[j-1];
      end
      if (en_o) ov_q <= dv_q[NDiv];
    end
  end

  // Stage 1: clamp the reveal factor; when alpha is zero substitute one for the colour sums and the divisor.
  assign sums_zero  = (in_i.sum_red | in_i.sum_green | in_i.sum_blue) == '0;
  assign alpha_zero = in_i.sum_alpha == '0;
  assign rv_sat     = in_i.reveal[16] ? wbr_pkg::RevealW'(wbr_pkg::OneQ16) : in_i.reveal;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      px1_q   <= in_i.dest_pixel;
      zero1_q <= sums_zero;
      c1_q[0] <= alpha_zero ? wbr_pkg::SumW'(1) : in_i.sum_red;
      c1_q[1] <= alpha_zero ? wbr_pkg::SumW'(1) : in_i.sum_green;
      c1_q[2] <= alpha_zero ? wbr_pkg::SumW'(1) : in_i.sum_blue;
      d1_q[0] <= in_i.dest_pixel[23:16];
      d1_q[1] <= in_i.dest_pixel[15:8];
      d1_q[2] <= in_i.dest_pixel[7:0];
      adiv1_q <= alpha_zero ? wbr_pkg::SumW'(1) : in_i.sum_alpha;
      araw1_q <= in_i.sum_alpha;
      rv1_q   <= rv_sat;
      inv1_q  <= wbr_pkg::RevealW'(wbr_pkg::OneQ16) - rv_sat;
    end
  end

  // Stage 2: colour and alpha sums times (1 - reveal), stored byte times reveal.
  always_ff @(posedge clk_i) begin
    if (en2) begin
      px2_q   <= px1_q;
      zero2_q <= zero1_q;
      for (int c = 0; c < wbr_pkg::NumChan; c++) begin
        p2_q[c]  <= 49'(c1_q[c]) * 49'(inv1_q);
        dr2_q[c] <= 25'(d1_q[c]) * 25'(rv1_q);
      end
      adiv2_q <= adiv1_q;
      pa2_q   <= 49'(araw1_q) * 49'(inv1_q);
    end
  end

  // Stage 3: numerator 255*C*(1-R) + D*R*A, and the alpha numerator.
  always_ff @(posedge clk_i) begin
    if (en3) begin
      px3_q   <= px2_q;
      zero3_q <= zero2_q;
      for (int c = 0; c < wbr_pkg::NumChan; c++) begin
        num3_q[c] <= 58'(57'({p2_q[c], 8'b0}) - 57'(p2_q[c]))
                   + 58'(57'(dr2_q[c]) * 57'(adiv2_q));
      end
      adiv3_q <= adiv2_q;
      a2553_q <= 40'({adiv2_q, 8'b0}) - 40'(adiv2_q);
      anum3_q <= 57'({pa2_q, 8'b0}) - 57'(pa2_q);
    end
  end

  // Divider entry: saturation check against 255 * (A << 16) and alpha rounding.
  always_comb begin
    logic [7:0]  aq;
    logic [31:0] ar;
    aq = anum3_q[39:32];
    ar = anum3_q[31:0];
    div_d[0].px   = px3_q;
    div_d[0].zero = zero3_q;
    if (anum3_q >= 57'({8'd255, 32'b0})) begin
      div_d[0].alpha = 8'd255;
    end else if (ar > 32'h8000_0000 || (ar == 32'h8000_0000 && aq[0])) begin
      div_d[0].alpha = aq + 8'd1;
    end else begin
      div_d[0].alpha = aq;
    end
    for (int c = 0; c < wbr_pkg::NumChan; c++) begin
      div_d[0].sat[c] = num3_q[c] >= 58'({a2553_q, 16'b0});
      div_d[0].rem[c] = num3_q[c][wbr_pkg::RemW-1:0];
      div_d[0].quo[c] = '0;
    end
    div_d[0].den = adiv3_q;
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  always_comb begin
    logic [wbr_pkg::RemW-1:0] trial;
    trial = '0;
    for (int j = 1; j <= NDiv; j++) begin
      div_d[j] = div_q[j-1];
      for (int c = 0; c < wbr_pkg::NumChan; c++) begin
        trial = wbr_pkg::RemW'({div_q[j-1].den, 16'b0}) << (NDiv - j);
        if (div_q[j-1].rem[c] >= trial) begin
          div_d[j].rem[c]            = div_q[j-1].rem[c] - trial;
          div_d[j].quo[c][NDiv - j]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= NDiv; j++) begin
      if (en_div[j]) div_q[j] <= div_d[j];
    end
  end

  // Final rounding to nearest, ties to even, and repacking.
  always_comb begin
    logic [wbr_pkg::NumChan-1:0][7:0] ch;
    logic [48:0] twice_r;
    logic [48:0] den48;
    twice_r = '0;
    den48   = 49'({div_q[NDiv].den, 16'b0});
    for (int c = 0; c < wbr_pkg::NumChan; c++) begin
      twice_r = {div_q[NDiv].rem[c][47:0], 1'b0};
      if (div_q[NDiv].sat[c]) begin
        ch[c] = 8'd255;
      end else if (twice_r > den48 || (twice_r == den48 && div_q[NDiv].quo[c][0])) begin
        ch[c] = div_q[NDiv].quo[c] + 8'd1;
      end else begin
        ch[c] = div_q[NDiv].quo[c];
      end
    end
    opx_d = div_q[NDiv].zero ? div_q[NDiv].px : {div_q[NDiv].alpha, ch[0], ch[1], ch[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en_o) opx_q <= opx_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_pixel = opx_q;

endmodule

>>> hw/rtl/wbr_checker.sv
module wbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_pixel_i
);

  // The input side only backs up when every stage is full and the output is stalled.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while output not stalled");

  // No output word appears in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

  // A stalled output word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output word dropped under stall");

  // A stalled output word keeps its value.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_pixel_i))
    else $error("output word changed under stall");

endmodule

bind weighted_blend_resolve wbr_checker u_wbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.out_pixel)
);

>>> sim/wbr_resolve_checker.sv
`timescale 1ns / 100ps

module wbr_resolve_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  wbr_in_if         in_i,
  wbr_out_if        out_o,
  output int        fail_count_o,
  output int        pending_o
);

  logic [wbr_pkg::PixelW-1:0] expected_pixels[$];
  int                         mismatch_count;
  int                         pending_count;

  // Clamp num/den to 255 and round to nearest, ties to even.
  function automatic logic [7:0] round_to_byte(logic [95:0] num, logic [95:0] den);
    logic [95:0] quo;
    logic [95:0] rem;
    if (num >= 96'd255 * den) return 8'hFF;
    quo = num / den;
    rem = num % den;
    if (2 * rem > den || (2 * rem == den && quo[0])) quo = quo + 1;
    return quo[7:0];
  endfunction

  function automatic logic [7:0] blend_chan(logic [wbr_pkg::SumW-1:0] csum,
                                            logic [wbr_pkg::SumW-1:0] asum,
                                            logic [7:0] dbyte, logic [16:0] rv);
    logic [95:0] inv;
    inv = 96'(wbr_pkg::OneQ16) - 96'(rv);
    if (asum == '0) begin
      return round_to_byte(96'd255 * inv + 96'(dbyte) * 96'(rv), 96'(wbr_pkg::OneQ16));
    end
    return round_to_byte(96'd255 * 96'(csum) * inv + 96'(dbyte) * 96'(rv) * 96'(asum),
                         96'(wbr_pkg::OneQ16) * 96'(asum));
  endfunction

  function automatic logic [wbr_pkg::PixelW-1:0] resolve_pixel(
      logic [wbr_pkg::PixelW-1:0] px, logic [wbr_pkg::SumW-1:0] sr,
      logic [wbr_pkg::SumW-1:0] sg, logic [wbr_pkg::SumW-1:0] sb,
      logic [wbr_pkg::SumW-1:0] sa, logic [wbr_pkg::RevealW-1:0] rv_in);
    logic [16:0] rv;
    logic [7:0]  alpha;
    if ((sr | sg | sb) == '0) return px;
    rv = (rv_in > wbr_pkg::OneQ16) ? 17'(wbr_pkg::OneQ16) : rv_in;
    alpha = round_to_byte(96'd255 * 96'(sa) * (96'(wbr_pkg::OneQ16) - 96'(rv)), 96'd1 << 32);
    return {alpha, blend_chan(sr, sa, px[23:16], rv), blend_chan(sg, sa, px[15:8], rv),
            blend_chan(sb, sa, px[7:0], rv)};
  endfunction

  // Queue an expectation for each input word and compare each output word.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [wbr_pkg::PixelW-1:0] exp_px;
    if (!rst_ni) begin
      mismatch_count = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_pixels.push_back(resolve_pixel(in_i.dest_pixel, in_i.sum_red, in_i.sum_green,
                                                in_i.sum_blue, in_i.sum_alpha, in_i.reveal));
      end
      if (out_o.valid && out_o.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected word %h", out_o.out_pixel);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px !== out_o.out_pixel) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("out_pixel mismatch: expected %h actual %h", exp_px, out_o.out_pixel);
          end
        end
      end
    end
    pending_count = expected_pixels.size();
  end

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NumRandom  = 1200;
  localparam int IdleLimit  = 20000;
  localparam int DrainWait  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   stall_long = 1'b0;

  wbr_in_if  in_ch ();
  wbr_out_if out_ch ();

  weighted_blend_resolve i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  wbr_resolve_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.dest_pixel = '0;
    in_ch.sum_red = '0;
    in_ch.sum_green = '0;
    in_ch.sum_blue = '0;
    in_ch.sum_alpha = '0;
    in_ch.reveal = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 0;
    if (sel < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Random 32-bit sum, often small or zero so that averages stay in range.
  function automatic logic [wbr_pkg::SumW-1:0] rand_sum();
    case ($urandom_range(5))
      0: return '0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic send_word(logic [wbr_pkg::PixelW-1:0] px, logic [wbr_pkg::SumW-1:0] sr,
                           logic [wbr_pkg::SumW-1:0] sg, logic [wbr_pkg::SumW-1:0] sb,
                           logic [wbr_pkg::SumW-1:0] sa, logic [wbr_pkg::RevealW-1:0] rv);
    in_ch.valid      <= 1'b1;
    in_ch.dest_pixel <= px;
    in_ch.sum_red    <= sr;
    in_ch.sum_green  <= sg;
    in_ch.sum_blue   <= sb;
    in_ch.sum_alpha  <= sa;
    in_ch.reveal     <= rv;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_random();
    logic [wbr_pkg::RevealW-1:0] rv;
    int gap;
    case ($urandom_range(4))
      0: rv = wbr_pkg::RevealW'($urandom());
      1: rv = wbr_pkg::RevealW'(wbr_pkg::OneQ16);
      2: rv = '0;
      default: rv = wbr_pkg::RevealW'($urandom_range(wbr_pkg::OneQ16));
    endcase
    send_word($urandom(), rand_sum(), rand_sum(), rand_sum(), rand_sum(), rv);
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random gaps, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        stall_long = 1'b0;
      end
      gap = gap_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("[weighted_blend_resolve] ERROR");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero sums, zero alpha, reveal extremes, saturating sums.
    send_word(32'h12345678, 0, 0, 0, 32'hFFFF_FFFF, 17'd1000);
    send_word(32'hFFFFFFFF, 0, 0, 0, 0, 17'h1FFFF);
    send_word(32'h00FF8040, 32'h0001_0000, 0, 0, 0, 17'd0);
    send_word(32'h00FF8040, 0, 0, 32'h1, 0, 17'd32768);
    send_word(32'h00000000, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0001_0000, 17'd0);
    send_word(32'hFFFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              17'd65536);
    send_word(32'h00102030, 32'hFFFF_FFFF, 32'h1, 32'h8000, 32'h1, 17'd65535);
    send_word(32'hAA55AA55, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000, 32'h0001_0000,
              17'd1);
    send_word(32'h80808080, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'hFFFF_FFFF,
              17'h1FFFF);
    send_word(32'h01010101, 32'h0000_0080, 32'h0000_0080, 32'h0000_0080, 32'h0000_0100,
              17'd65537);
    send_word(32'hFFFFFFFF, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF, 17'd0);

    // Random part; the receiver stalls long once while words keep coming, and the input pauses once to drain.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) stall_long = 1'b1;
      if (n == 700) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    // Let the last accepted word be queued before draining.
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[weighted_blend_resolve] OK");
    end else begin
      $display("[weighted_blend_resolve] ERROR");
    end
    $finish;
  end
endmodule
